// File: hw/rtl/intel_hex_record_parser_core_macros.svh
// Assertion macros shared by the checker.
`ifndef INTEL_HEX_RECORD_PARSER_CORE_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define IHEX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ihex assertion failed");

// Next-cycle implication, off while reset is held.
`define IHEX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ihex assertion failed");

// Condition that must hold in the cycle after reset is seen.
`define IHEX_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("ihex reset assertion failed");

`endif

// File: hw/rtl/ihex_pkg.sv
package ihex_pkg;

    localparam int FRONT_DEPTH_DEF  = 2;
    localparam int RESULT_DEPTH_DEF = 2;

    localparam logic [16:0] IMAGE_LIMIT_RST = 17'd7168;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [7:0] RT_DATA = 8'h00;
    localparam logic [7:0] RT_EOF  = 8'h01;

    localparam logic [1:0] RK_DATA     = 2'd0;
    localparam logic [1:0] RK_REC_END  = 2'd1;
    localparam logic [1:0] RK_FINISHED = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_HEX   = 3'd2;
    localparam logic [2:0] ST_LENGTH    = 3'd3;
    localparam logic [2:0] ST_CHECKSUM  = 3'd4;
    localparam logic [2:0] ST_RANGE     = 3'd5;
    localparam logic [2:0] ST_NO_END    = 3'd6;

    // One classified input item as handed from front to back.
    typedef struct packed {
        logic       eos;
        logic       is_hex;
        logic [3:0] nib;
        logic       is_colon;
        logic       is_cr;
        logic       is_lf;
    } t_cls;

    typedef struct packed {
        logic [1:0]  kind;
        logic [16:0] addr;
        logic [7:0]  data;
        logic [7:0]  rtype;
        logic [2:0]  status;
    } t_res;

    // Bit 4 set marks a character that is no hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b0, d[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b0, d[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b0, d[3:0]};
        end
        return 5'b1_0000;
    endfunction

endpackage

// File: hw/rtl/ihex_front.sv
module ihex_front #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic            i_kind,
    input  logic [7:0]      i_ch,
    output logic            o_valid,
    output ihex_pkg::t_cls  o_cls,
    input  logic            i_take
);
    import ihex_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_q [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cls             cls;
    logic [4:0]       hv;
    logic             wr, rd;

    always_comb begin
        hv           = hex_value(i_ch);
        cls.eos      = i_kind;
        cls.is_hex   = ~hv[4];
        cls.nib      = hv[3:0];
        cls.is_colon = (i_ch == CH_COLON);
        cls.is_cr    = (i_ch == CH_CR);
        cls.is_lf    = (i_ch == CH_LF);
    end

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cls   = r_q[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_take && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

// File: hw/rtl/ihex_back.sv
module ihex_back #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [16:0]     i_cfg_wdata,
    input  logic            i_valid,
    input  ihex_pkg::t_cls  i_cls,
    output logic            o_take,
    output ihex_pkg::t_res  o_res,
    output logic            o_empty,
    input  logic            i_pop
);
    import ihex_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [3:0] PH_COLON    = 4'd0;
    localparam logic [3:0] PH_LEN      = 4'd1;
    localparam logic [3:0] PH_ADDR     = 4'd2;
    localparam logic [3:0] PH_TYPE     = 4'd3;
    localparam logic [3:0] PH_DATA     = 4'd4;
    localparam logic [3:0] PH_CKS      = 4'd5;
    localparam logic [3:0] PH_TAIL     = 4'd6;
    localparam logic [3:0] PH_AFTER_CR = 4'd7;
    localparam logic [3:0] PH_SKIP     = 4'd8;

    logic [16:0] r_limit;
    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_nib, n_nib;
    logic [15:0] r_acc, n_acc;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_seen, n_seen;
    logic [7:0]  r_sum, n_sum;
    logic        r_halt, n_halt;

    t_res             r_q [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic        emit;
    t_res        res;
    logic        do_fail, do_end;
    logic [2:0]  fail_code;
    logic [15:0] acc_next;
    logic [2:0]  nib_next;
    logic [2:0]  need;
    logic [7:0]  seen_next;
    logic [16:0] end_addr;
    logic        rd;

    assign o_take  = i_valid && (r_cnt != CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rp];
    assign rd      = i_pop && !o_empty;

    assign acc_next  = {r_acc[11:0], i_cls.nib};
    assign nib_next  = r_nib + 3'd1;
    assign need      = (r_phase == PH_ADDR) ? 3'd4 : 3'd2;
    assign seen_next = r_seen + 8'd1;
    assign end_addr  = {1'b0, r_addr} + {9'd0, r_len};

    always_comb begin
        n_phase   = r_phase;
        n_nib     = r_nib;
        n_acc     = r_acc;
        n_len     = r_len;
        n_addr    = r_addr;
        n_type    = r_type;
        n_seen    = r_seen;
        n_sum     = r_sum;
        n_halt    = r_halt;
        emit      = 1'b0;
        res       = '0;
        do_fail   = 1'b0;
        do_end    = 1'b0;
        fail_code = ST_OK;

        if (o_take && !r_halt) begin
            if (i_cls.eos) begin
                n_halt     = 1'b1;
                emit       = 1'b1;
                res.kind   = RK_FINISHED;
                res.status = ST_NO_END;
            end else begin
                unique case (r_phase)
                    PH_COLON: begin
                        if (!i_cls.is_colon) begin
                            do_fail   = 1'b1;
                            fail_code = ST_BAD_START;
                        end else begin
                            n_nib   = '0;
                            n_acc   = '0;
                            n_len   = '0;
                            n_addr  = '0;
                            n_type  = '0;
                            n_seen  = '0;
                            n_sum   = '0;
                            n_phase = PH_LEN;
                        end
                    end
                    PH_SKIP: begin
                        if (i_cls.is_lf) begin
                            emit      = 1'b1;
                            res.rtype = r_type;
                            if (r_type == RT_EOF) begin
                                n_halt   = 1'b1;
                                res.kind = RK_FINISHED;
                            end else begin
                                n_phase  = PH_COLON;
                                res.kind = RK_REC_END;
                            end
                        end
                    end
                    PH_TAIL: begin
                        if (i_cls.is_cr) begin
                            n_phase = PH_AFTER_CR;
                        end else if (i_cls.is_lf) begin
                            do_end = 1'b1;
                        end else begin
                            do_fail   = 1'b1;
                            fail_code = ST_LENGTH;
                        end
                    end
                    PH_AFTER_CR: begin
                        if (i_cls.is_lf) begin
                            do_end = 1'b1;
                        end else begin
                            do_fail   = 1'b1;
                            fail_code = ST_LENGTH;
                        end
                    end
                    PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CKS: begin
                        if (!i_cls.is_hex) begin
                            do_fail   = 1'b1;
                            fail_code = (i_cls.is_cr || i_cls.is_lf) ? ST_LENGTH : ST_BAD_HEX;
                        end else if (nib_next < need) begin
                            n_acc = acc_next;
                            n_nib = nib_next;
                        end else begin
                            n_nib = '0;
                            n_acc = '0;
                            case (r_phase)
                                PH_LEN: begin
                                    n_len   = acc_next[7:0];
                                    n_phase = PH_ADDR;
                                end
                                PH_ADDR: begin
                                    n_addr  = acc_next;
                                    n_phase = PH_TYPE;
                                end
                                PH_TYPE: begin
                                    n_type = acc_next[7:0];
                                    n_sum  = r_len + r_addr[15:8] + r_addr[7:0] + acc_next[7:0];
                                    if (acc_next[7:0] == RT_DATA) begin
                                        n_phase = (r_len == 8'd0) ? PH_CKS : PH_DATA;
                                    end else begin
                                        n_phase = PH_SKIP;
                                    end
                                end
                                PH_DATA: begin
                                    n_sum     = r_sum + acc_next[7:0];
                                    n_seen    = seen_next;
                                    emit      = 1'b1;
                                    res.kind  = RK_DATA;
                                    res.addr  = {1'b0, r_addr} + {9'd0, r_seen};
                                    res.data  = acc_next[7:0];
                                    res.rtype = r_type;
                                    if (seen_next == r_len) begin
                                        n_phase = PH_CKS;
                                    end
                                end
                                default: begin
                                    n_sum   = r_sum + acc_next[7:0];
                                    n_phase = PH_TAIL;
                                end
                            endcase
                        end
                    end
                    default: begin
                        do_fail   = 1'b1;
                        fail_code = ST_LENGTH;
                    end
                endcase
            end
        end

        // Checksum takes precedence over range at the line end.
        if (do_end) begin
            if (r_sum != 8'd0) begin
                do_fail   = 1'b1;
                fail_code = ST_CHECKSUM;
            end else if (end_addr > r_limit) begin
                do_fail   = 1'b1;
                fail_code = ST_RANGE;
            end else begin
                n_phase    = PH_COLON;
                emit       = 1'b1;
                res.kind   = RK_REC_END;
                res.rtype  = r_type;
                res.status = ST_OK;
            end
        end

        if (do_fail) begin
            n_halt     = 1'b1;
            emit       = 1'b1;
            res.kind   = RK_REC_END;
            res.addr   = '0;
            res.data   = '0;
            res.rtype  = r_type;
            res.status = fail_code;
        end
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (emit) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (emit && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !emit) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= IMAGE_LIMIT_RST;
            r_phase <= PH_COLON;
            r_nib   <= '0;
            r_acc   <= '0;
            r_len   <= '0;
            r_addr  <= '0;
            r_type  <= '0;
            r_seen  <= '0;
            r_sum   <= '0;
            r_halt  <= 1'b0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_phase <= n_phase;
            r_nib   <= n_nib;
            r_acc   <= n_acc;
            r_len   <= n_len;
            r_addr  <= n_addr;
            r_type  <= n_type;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
            r_halt  <= n_halt;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_q[r_wp] <= res;
        end
    end

endmodule

// File: hw/rtl/intel_hex_record_parser_core.sv
// Channel   Direction  Handshake          Payload
// input     in         push / full        i_kind, i_ch
// result    out        empty / pop        o_result_kind, o_byte_address, o_data_byte,
//                                         o_record_type, o_status
// config    in         i_cfg_we           i_cfg_wdata (image limit)
//
// One character per cycle sustained while the result queue has room; a result passes the
// front queue register and then the result queue register before it is on the ports.
// The front queue holds classified characters, the back parser takes one per cycle while
// its result queue has room, so a stalled reader backs up into full after both queues fill.
// Reset is synchronous and empties both queues; the image limit returns to 7168.
module intel_hex_record_parser_core #(
    parameter int FRONT_DEPTH  = ihex_pkg::FRONT_DEPTH_DEF,
    parameter int RESULT_DEPTH = ihex_pkg::RESULT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [7:0]  i_ch,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_result_kind,
    output logic [16:0] o_byte_address,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_record_type,
    output logic [2:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata
);
    import ihex_pkg::*;

    logic fq_valid;
    logic fq_take;
    t_cls fq_cls;
    t_res res;

    ihex_front #(
        .DEPTH (FRONT_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_kind  (i_kind),
        .i_ch    (i_ch),
        .o_valid (fq_valid),
        .o_cls   (fq_cls),
        .i_take  (fq_take)
    );

    ihex_back #(
        .DEPTH (RESULT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (fq_valid),
        .i_cls       (fq_cls),
        .o_take      (fq_take),
        .o_res       (res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_result_kind  = res.kind;
    assign o_byte_address = res.addr;
    assign o_data_byte    = res.data;
    assign o_record_type  = res.rtype;
    assign o_status       = res.status;

endmodule

// File: hw/rtl/ihex_checker.sv
`include "intel_hex_record_parser_core_macros.svh"

module ihex_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_result_kind,
    input logic [16:0] o_byte_address,
    input logic [7:0]  o_data_byte,
    input logic [2:0]  o_status
);
    import ihex_pkg::*;

    logic r_done;
    logic last_taken;

    // A finished result or any error closes the stream.
    assign last_taken = pop && !empty
                        && (o_result_kind == RK_FINISHED || o_status != ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (last_taken) begin
            r_done <= 1'b1;
        end
    end

    `IHEX_ASSERT_RST(a_empty_after_rst, empty)
    `IHEX_ASSERT_IMP(a_quiet_after_end, r_done, empty)
    `IHEX_ASSERT_IMP(a_data_ok, !empty && o_result_kind == RK_DATA, o_status == ST_OK)
    `IHEX_ASSERT_NXT(a_hold_stalled, !empty && !pop, !empty && $stable(o_byte_address) && $stable(o_data_byte))

endmodule

bind intel_hex_record_parser_core ihex_checker u_ihex_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_result_kind  (o_result_kind),
    .o_byte_address (o_byte_address),
    .o_data_byte    (o_data_byte),
    .o_status       (o_status)
);

// File: tb/intel_hex_record_parser_core_test.sv
module intel_hex_record_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ihex_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CFG_SETTLE     = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_CHARS    = 300;

    typedef enum logic [3:0] {
        AWAIT_COLON, GET_LEN, GET_ADDR, GET_TYPE, GET_DATA, GET_CKS, GET_TAIL, GET_LF, SKIP_BODY
    } t_parse_phase;

    typedef enum {
        CLOSE_BAD_START, CLOSE_BAD_HEX, CLOSE_LENGTH, CLOSE_CHECKSUM, CLOSE_RANGE,
        CLOSE_EOF_RECORD, CLOSE_NO_EOF
    } t_stream_close;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        i_kind      = 1'b0;
    logic [7:0]  i_ch        = 8'h00;
    logic        pop         = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [16:0] i_cfg_wdata = 17'd0;
    logic        full;
    logic        empty;
    logic [1:0]  o_result_kind;
    logic [16:0] o_byte_address;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_record_type;
    logic [2:0]  o_status;

    intel_hex_record_parser_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_ch           (i_ch),
        .empty          (empty),
        .pop            (pop),
        .o_result_kind  (o_result_kind),
        .o_byte_address (o_byte_address),
        .o_data_byte    (o_data_byte),
        .o_record_type  (o_record_type),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Parser state mirrored by the testbench
    t_parse_phase phase_q         = AWAIT_COLON;
    logic [2:0]   nib_q           = 3'd0;
    logic [15:0]  accum_q         = 16'h0000;
    logic [7:0]   rec_len_q       = 8'h00;
    logic [15:0]  rec_addr_q      = 16'h0000;
    logic [7:0]   rec_type_q      = 8'h00;
    logic [7:0]   seen_q          = 8'h00;
    logic [7:0]   sum_q           = 8'h00;
    logic         parser_halted   = 1'b0;
    logic [16:0]  image_limit_cfg = IMAGE_LIMIT_RST;

    t_res          expected_results[$];
    logic [7:0]    line_buf[$];
    int            send_idle_pct   = 0;
    int            recv_stall_pct  = 0;
    int            mismatch_count  = 0;
    int            results_checked = 0;
    int            chars_sent      = 0;
    int            records_built   = 0;
    int            idle_cycles     = 0;
    t_stream_close close_case      = CLOSE_NO_EOF;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    function automatic void queue_result(input logic [1:0] kind, input logic [16:0] addr,
                                         input logic [7:0] data, input logic [7:0] rt,
                                         input logic [2:0] st);
        t_res r;
        r.kind   = kind;
        r.addr   = addr;
        r.data   = data;
        r.rtype  = rt;
        r.status = st;
        expected_results.push_back(r);
    endfunction

    function automatic void halt_with(input logic [2:0] st);
        parser_halted = 1'b1;
        queue_result(RK_REC_END, '0, '0, rec_type_q, st);
    endfunction

    // Checksum takes precedence over the range check
    function automatic void close_line();
        if (sum_q != 8'h00) begin
            halt_with(ST_CHECKSUM);
        end else if ({1'b0, rec_addr_q} + {9'd0, rec_len_q} > image_limit_cfg) begin
            halt_with(ST_RANGE);
        end else begin
            phase_q = AWAIT_COLON;
            queue_result(RK_REC_END, '0, '0, rec_type_q, ST_OK);
        end
    endfunction

    function automatic void parse_char(input logic k, input logic [7:0] c);
        logic [4:0]  hv;
        logic [15:0] field;
        logic [2:0]  need;
        if (parser_halted) return;
        if (k) begin
            parser_halted = 1'b1;
            queue_result(RK_FINISHED, '0, '0, '0, ST_NO_END);
            return;
        end
        case (phase_q)
            AWAIT_COLON: begin
                if (c != CH_COLON) begin
                    halt_with(ST_BAD_START);
                end else begin
                    nib_q      = '0;
                    accum_q    = '0;
                    rec_len_q  = '0;
                    rec_addr_q = '0;
                    rec_type_q = '0;
                    seen_q     = '0;
                    sum_q      = '0;
                    phase_q    = GET_LEN;
                end
                return;
            end
            SKIP_BODY: begin
                if (c != CH_LF) return;
                if (rec_type_q == RT_EOF) begin
                    parser_halted = 1'b1;
                    queue_result(RK_FINISHED, '0, '0, rec_type_q, ST_OK);
                end else begin
                    phase_q = AWAIT_COLON;
                    queue_result(RK_REC_END, '0, '0, rec_type_q, ST_OK);
                end
                return;
            end
            GET_TAIL: begin
                if (c == CH_CR) phase_q = GET_LF;
                else if (c == CH_LF) close_line();
                else halt_with(ST_LENGTH);
                return;
            end
            GET_LF: begin
                if (c == CH_LF) close_line();
                else halt_with(ST_LENGTH);
                return;
            end
            default: ;
        endcase

        hv = hex_nibble(c);
        if (hv[4]) begin
            halt_with((c == CH_CR || c == CH_LF) ? ST_LENGTH : ST_BAD_HEX);
            return;
        end
        accum_q = {accum_q[11:0], hv[3:0]};
        nib_q   = nib_q + 3'd1;
        need    = (phase_q == GET_ADDR) ? 3'd4 : 3'd2;
        if (nib_q < need) return;
        field   = accum_q;
        nib_q   = '0;
        accum_q = '0;

        case (phase_q)
            GET_LEN: begin
                rec_len_q = field[7:0];
                phase_q   = GET_ADDR;
            end
            GET_ADDR: begin
                rec_addr_q = field;
                phase_q    = GET_TYPE;
            end
            GET_TYPE: begin
                rec_type_q = field[7:0];
                sum_q = rec_len_q + rec_addr_q[15:8] + rec_addr_q[7:0] + rec_type_q;
                if (rec_type_q != RT_DATA) phase_q = SKIP_BODY;
                else if (rec_len_q == 8'h00) phase_q = GET_CKS;
                else phase_q = GET_DATA;
            end
            GET_DATA: begin
                sum_q = sum_q + field[7:0];
                queue_result(RK_DATA, {1'b0, rec_addr_q} + {9'd0, seen_q}, field[7:0],
                             rec_type_q, ST_OK);
                seen_q = seen_q + 8'd1;
                if (seen_q == rec_len_q) phase_q = GET_CKS;
            end
            default: begin
                sum_q   = sum_q + field[7:0];
                phase_q = GET_TAIL;
            end
        endcase
    endfunction

    // Append two hex digits, letters in random case
    function automatic void put_hex(input logic [7:0] b);
        logic [3:0] n;
        for (int i = 1; i >= 0; i--) begin
            n = b[i*4 +: 4];
            if (n < 4'd10) line_buf.push_back(8'h30 + {4'd0, n});
            else if ($urandom_range(1) == 1) line_buf.push_back(8'h61 + {4'd0, n} - 8'd10);
            else line_buf.push_back(8'h41 + {4'd0, n} - 8'd10);
        end
    endfunction

    function automatic void build_data_record(input logic [7:0] len, input logic [15:0] addr,
                                              input logic bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        line_buf.delete();
        line_buf.push_back(CH_COLON);
        sum = len + addr[15:8] + addr[7:0] + RT_DATA;
        put_hex(len);
        put_hex(addr[15:8]);
        put_hex(addr[7:0]);
        put_hex(RT_DATA);
        repeat (len) begin
            b   = 8'($urandom_range(255));
            sum = sum + b;
            put_hex(b);
        end
        sum = -sum;
        if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
        put_hex(sum);
        if ($urandom_range(1) == 1) line_buf.push_back(CH_CR);
        line_buf.push_back(CH_LF);
        records_built++;
    endfunction

    // Length and address are arbitrary, body is any text short of a line feed
    function automatic void build_skip_record(input logic [7:0] rt);
        logic [7:0] j;
        line_buf.delete();
        line_buf.push_back(CH_COLON);
        put_hex(8'($urandom_range(255)));
        put_hex(8'($urandom_range(255)));
        put_hex(8'($urandom_range(255)));
        put_hex(rt);
        repeat ($urandom_range(0, 20)) begin
            if ($urandom_range(1) == 1) begin
                put_hex(8'($urandom_range(255)));
            end else begin
                do j = 8'($urandom_range(255)); while (j == CH_LF);
                line_buf.push_back(j);
            end
        end
        line_buf.push_back(CH_LF);
        records_built++;
    endfunction

    // Data record that passes the current limit; returns its length
    function automatic int build_fitting_record(input int max_len, input logic bad_sum);
        int lim;
        int len;
        int span;
        int addr;
        lim = int'(image_limit_cfg);
        if (max_len > lim) max_len = lim;
        len  = $urandom_range(0, max_len);
        span = lim - len;
        if (span > 65535) span = 65535;
        addr = ($urandom_range(9) == 0) ? span : $urandom_range(0, span);
        build_data_record(len[7:0], addr[15:0], bad_sum);
        return len;
    endfunction

    task automatic send_item(input logic k, input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_kind <= k;
        i_ch   <= c;
        do @(posedge i_clk); while (full);
        parse_char(k, c);
        chars_sent++;
    endtask

    task automatic send_chars(input int first, input int last);
        for (int i = first; i < last; i++) send_item(1'b0, line_buf[i]);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_image_limit(input logic [16:0] v);
        wait_drained();
        // let characters still in flight that give no result clear the block
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        image_limit_cfg  = v;
    endtask

    task automatic send_random_record();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            if ($urandom_range(1) == 1) build_skip_record(8'($urandom_range(2, 5)));
            else build_skip_record(8'($urandom_range(2, 255)));
        end else if (pick < 88) begin
            void'(build_fitting_record(16, 1'b0));
        end else if (pick < 98) begin
            void'(build_fitting_record(64, 1'b0));
        end else begin
            void'(build_fitting_record(255, 1'b0));
        end
        send_chars(0, line_buf.size());
    endtask

    task automatic test_default_limit();
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        build_data_record(8'd4, 16'h0000, 1'b0);
        send_chars(0, line_buf.size());
        build_data_record(8'd16, 16'($urandom_range(0, 7152)), 1'b0);
        send_chars(0, line_buf.size());
        // zero length and eight bytes both ending exactly at the limit
        build_data_record(8'd0, 16'd7168, 1'b0);
        send_chars(0, line_buf.size());
        build_data_record(8'd8, 16'd7160, 1'b0);
        send_chars(0, line_buf.size());
        for (int rt = 2; rt <= 5; rt++) begin
            build_skip_record(8'(rt));
            send_chars(0, line_buf.size());
        end
        build_skip_record(8'h02);
        void'(line_buf.pop_back());
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_LF);
        send_chars(0, line_buf.size());
        // hold the sender mid-record until the pending data bytes are out
        build_data_record(8'd8, 16'h0100, 1'b0);
        send_chars(0, 13);
        wait_drained();
        send_chars(13, line_buf.size());
    endtask

    task automatic test_limit_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_image_limit(17'd65536);
        build_data_record(8'd1, 16'hFFFF, 1'b0);
        send_chars(0, line_buf.size());
        build_data_record(8'hFF, 16'hFF01, 1'b0);
        send_chars(0, line_buf.size());
        build_data_record(8'd0, 16'hFFFF, 1'b0);
        send_chars(0, line_buf.size());
        write_image_limit(17'd0);
        build_data_record(8'd0, 16'h0000, 1'b0);
        send_chars(0, line_buf.size());
        build_skip_record(8'hFF);
        send_chars(0, line_buf.size());
    endtask

    task automatic test_random_records();
        int start;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_image_limit(17'd65536);
                end
                1: begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 0;
                    write_image_limit(17'($urandom_range(0, 65536)));
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 60;
                    write_image_limit(17'($urandom_range(0, 300)));
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                    write_image_limit(IMAGE_LIMIT_RST);
                end
            endcase
            start = chars_sent;
            while (chars_sent - start < PHASE_CHARS) send_random_record();
        end
    endtask

    // Only one terminating event per run: the parser stays halted until reset
    task automatic test_stream_end();
        int         len;
        int         p;
        int         lo;
        int         lim;
        logic [7:0] c;
        close_case = t_stream_close'($urandom_range(0, 6));
        case (close_case)
            CLOSE_BAD_START: begin
                p = $urandom_range(2);
                if (p == 0) c = CH_CR;
                else if (p == 1) c = CH_LF;
                else do c = 8'($urandom_range(255)); while (c == CH_COLON);
                send_item(1'b0, c);
            end
            CLOSE_BAD_HEX: begin
                len = build_fitting_record(16, 1'b0);
                p = $urandom_range(1, 10 + 2 * len);
                do begin
                    c = 8'($urandom_range(255));
                end while (hex_nibble(c) != 5'h10 || c == CH_CR || c == CH_LF);
                line_buf[p] = c;
                send_chars(0, p + 1);
            end
            CLOSE_LENGTH: begin
                len = build_fitting_record(16, 1'b0);
                case ($urandom_range(2))
                    0: begin
                        p = $urandom_range(1, 10 + 2 * len);
                        line_buf[p] = ($urandom_range(1) == 1) ? CH_CR : CH_LF;
                        send_chars(0, p + 1);
                    end
                    1: begin
                        p = 11 + 2 * len;
                        do c = 8'($urandom_range(255)); while (c == CH_CR || c == CH_LF);
                        line_buf[p] = c;
                        send_chars(0, p + 1);
                    end
                    default: begin
                        p = 11 + 2 * len;
                        while (line_buf.size() > p) void'(line_buf.pop_back());
                        line_buf.push_back(CH_CR);
                        do c = 8'($urandom_range(255)); while (c == CH_LF);
                        line_buf.push_back(c);
                        send_chars(0, p + 2);
                    end
                endcase
            end
            CLOSE_CHECKSUM: begin
                void'(build_fitting_record(16, 1'b1));
                send_chars(0, line_buf.size());
            end
            CLOSE_RANGE: begin
                lim = int'(image_limit_cfg);
                len = $urandom_range(1, 255);
                lo  = lim - len + 1;
                if (lo < 0) lo = 0;
                if (lo > 65535) begin
                    len = 255;
                    lo  = lim - 254;
                end
                build_data_record(len[7:0], 16'($urandom_range(lo, 65535)), 1'b0);
                send_chars(0, line_buf.size());
            end
            CLOSE_EOF_RECORD: begin
                build_skip_record(RT_EOF);
                send_chars(0, line_buf.size());
            end
            default: begin
                void'(build_fitting_record(16, 1'b0));
                send_chars(0, $urandom_range(0, line_buf.size()));
                send_item(1'b1, 8'($urandom_range(255)));
            end
        endcase
        // everything after the halt must be dropped silently
        repeat (40) send_item($urandom_range(99) < 25, 8'($urandom_range(255)));
    endtask

    function automatic void check_field(input string name, input logic [16:0] want,
                                        input logic [16:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display({"%0t: result with none expected: ",
                          "kind %0h addr %0h data %0h type %0h status %0h"},
                         $time, o_result_kind, o_byte_address, o_data_byte, o_record_type,
                         o_status);
            end else begin
                want = expected_results.pop_front();
                check_field("result_kind", 17'(want.kind), 17'(o_result_kind));
                check_field("byte_address", want.addr, o_byte_address);
                check_field("data_byte", 17'(want.data), 17'(o_data_byte));
                check_field("record_type", 17'(want.rtype), 17'(o_record_type));
                check_field("status", 17'(want.status), 17'(o_status));
                results_checked++;
            end
        end
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_results.size());
                $display("intel_hex_record_parser_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_limit();
        test_limit_extremes();
        test_random_records();
        test_stream_end();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display({"Covered %0d characters in %0d records across four idle patterns ",
                  "and limits 0 to 65536"}, chars_sent, records_built);
        $display("Checked %0d results; stream closed by %s", results_checked, close_case.name());
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("intel_hex_record_parser_core verification clean");
        end else begin
            $display("intel_hex_record_parser_core verification failed");
        end
        $finish;
    end

endmodule
